[src/nnsa_pkg.sv]
// Package for the nearest-neighbor scaler address unit.
// Field widths, register reset values, register index and step sequencer codes.
// No dependencies.
package nnsa_pkg;

  localparam int COORD_W   = 11;               // destination coordinate width
  localparam int DIM_W     = 12;               // dimension register width
  localparam int OFS_W     = 22;               // byte offset width
  localparam int FRAC_W    = 10;               // fraction bits of the column step
  localparam int STEP_W    = DIM_W + FRAC_W;   // column step width
  localparam int CFG_IDX_W = 2;
  localparam int MAX_DIM   = 2048;

  // row divider: quotient bits resolved per pipeline stage
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = DIM_W / DIV_STEPS;

  localparam int SRC_W_RST = 320;
  localparam int SRC_H_RST = 200;
  localparam int DST_W_RST = 320;
  localparam int DST_H_RST = 200;
  localparam int STEP_RST  = (SRC_W_RST * (2 ** FRAC_W)) / DST_W_RST;

  localparam int STEP_CNT_W = $clog2(STEP_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_W = 2'd0,
    REG_SRC_H = 2'd1,
    REG_DST_W = 2'd2,
    REG_DST_H = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STEP_IDLE,
    STEP_LOAD,
    STEP_RUN
  } step_state_t;

endpackage

[src/nnsa_if.sv]
// Valid/ready channel interfaces of the nearest-neighbor scaler address unit.
// Depends on nnsa_pkg for the field widths.
interface nnsa_in_if;
  import nnsa_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] dst_x;
  logic [COORD_W-1:0] dst_y;

  modport source (output valid, output dst_x, output dst_y, input ready);
  modport sink   (input valid, input dst_x, input dst_y, output ready);
endinterface

interface nnsa_out_if;
  import nnsa_pkg::*;

  logic             valid;
  logic             ready;
  logic [OFS_W-1:0] src_byte_ofs;
  logic [OFS_W-1:0] dst_offset;
  logic             in_range;

  modport source (output valid, output src_byte_ofs, output dst_offset, output in_range,
                  input ready);
  modport sink   (input valid, input src_byte_ofs, input dst_offset, input in_range,
                  output ready);
endinterface

[src/nearest_neighbor_scale_address.sv]
// Nearest-neighbor scaler address unit.
//
// in_ch carries destination coordinates (dst_x, dst_y); out_ch returns, per coordinate,
// the source pixel byte offset, the destination byte offset and in_range. Both are
// valid/ready channels; a transfer happens on a clock edge with valid and ready high.
// The cfg port writes src_width, src_height, dst_width, dst_height (indexes 0..3);
// values above MAX_DIM saturate. Write only while no item is in flight.
//
// One coordinate is taken every cycle while the column step is not being recomputed
// and the receiver does not stall the pipeline. The row divide runs as a pipelined
// restoring divider, three quotient bits per stage over four stages. The column step
// is held in a register and recomputed by a bit-serial divider after a write to
// src_width or dst_width: after such a write, in_ch.ready stays low until that divide is done.
// Every stage has a valid bit and its own enable, so a stalled receiver holds the
// output register and bubbles still close up; nothing is dropped or repeated.
// Synchronous active-low reset empties the pipeline and loads the register defaults
// (320 x 200 to 320 x 200) together with the matching column step.
// Depends on nnsa_pkg and the interfaces in nnsa_if.sv.
module nearest_neighbor_scale_address (
  input  logic                            clk,
  input  logic                            rst_n,
  nnsa_in_if.sink                         in_ch,
  nnsa_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [nnsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nnsa_pkg::DIM_W-1:0]      cfg_wdata
);
  import nnsa_pkg::*;

  typedef struct packed {
    logic             ok;
    logic [OFS_W-1:0] dst_off;
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] rem;
    logic [DIM_W-1:0] num;
    logic [DIM_W-1:0] quo;
  } stage_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if ({1'b0, v} > (DIM_W+1)'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return v;
  endfunction

  // resolve DIV_STEPS quotient bits of the row divide
  function automatic stage_t div_bits(input stage_t s, input logic [DIM_W-1:0] d);
    stage_t         r;
    logic [DIM_W:0] t;
    r = s;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t     = {r.rem, r.num[DIM_W-1]};
      r.num = {r.num[DIM_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t     = t - {1'b0, d};
        r.quo = {r.quo[DIM_W-2:0], 1'b1};
      end else begin
        r.quo = {r.quo[DIM_W-2:0], 1'b0};
      end
      r.rem = t[DIM_W-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [DIM_W-1:0] src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic             step_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= DIM_W'(SRC_W_RST);
      src_h_r <= DIM_W'(SRC_H_RST);
      dst_w_r <= DIM_W'(DST_W_RST);
      dst_h_r <= DIM_W'(DST_H_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_W: src_w_r <= clamp_dim(cfg_wdata);
        REG_SRC_H: src_h_r <= clamp_dim(cfg_wdata);
        REG_DST_W: dst_w_r <= clamp_dim(cfg_wdata);
        REG_DST_H: dst_h_r <= clamp_dim(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign step_wr = cfg_we && (cfg_index == REG_SRC_W || cfg_index == REG_DST_W);

  // column step sequencer: step = (src_width << FRAC_W) / dst_width, one bit a cycle
  step_state_t           state_r, state_nxt;
  logic [STEP_CNT_W-1:0] cnt_r;
  logic [DIM_W-1:0]      srem_r;
  logic [STEP_W-1:0]     snum_r;
  logic [STEP_W-1:0]     step_r;
  logic [DIM_W:0]        strial;
  logic                  sfits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STEP_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      STEP_IDLE: state_nxt = STEP_IDLE;
      STEP_LOAD: state_nxt = STEP_RUN;
      STEP_RUN: begin
        if (cnt_r == STEP_CNT_W'(STEP_W - 1)) begin
          state_nxt = STEP_IDLE;
        end
      end
      default: state_nxt = STEP_IDLE;
    endcase
    // a new width restarts the divide
    if (step_wr) begin
      state_nxt = STEP_LOAD;
    end
  end

  assign strial = {srem_r, snum_r[STEP_W-1]};
  assign sfits  = strial >= {1'b0, dst_w_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_W'(STEP_RST);
      cnt_r  <= '0;
    end else begin
      case (state_r)
        STEP_LOAD: begin
          srem_r <= '0;
          snum_r <= {src_w_r, {FRAC_W{1'b0}}};
          cnt_r  <= '0;
        end
        STEP_RUN: begin
          snum_r <= {snum_r[STEP_W-2:0], 1'b0};
          cnt_r  <= cnt_r + 1'b1;
          if (sfits) begin
            srem_r <= DIM_W'(strial - {1'b0, dst_w_r});
          end else begin
            srem_r <= strial[DIM_W-1:0];
          end
          step_r <= {step_r[STEP_W-2:0], sfits};
        end
        default: ;
      endcase
    end
  end

  // address pipeline
  stage_t                   p_r [DIV_STAGES+1];
  logic [DIV_STAGES:0]      v_r;
  logic [DIV_STAGES:0]      en;
  logic                     en_out;
  logic                     in_xfer;
  stage_t                   s0;
  logic [COORD_W+DIM_W-1:0] ny;
  logic [COORD_W+DIM_W-1:0] dy;
  logic [COORD_W+STEP_W-1:0] xs;
  logic [2*DIM_W-1:0]       src_sum;

  logic             out_valid_r;
  logic [OFS_W-1:0] out_src_r;
  logic [OFS_W-1:0] out_dst_r;
  logic             out_rng_r;

  always_comb begin
    en_out         = !out_valid_r || out_ch.ready;
    en[DIV_STAGES] = !v_r[DIV_STAGES] || en_out;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ch.ready = en[0] && (state_r == STEP_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    ny = (COORD_W+DIM_W)'(in_ch.dst_y) * (COORD_W+DIM_W)'(src_h_r);
    dy = (COORD_W+DIM_W)'(in_ch.dst_y) * (COORD_W+DIM_W)'(dst_w_r)
       + (COORD_W+DIM_W)'(in_ch.dst_x);
    xs = (COORD_W+STEP_W)'(in_ch.dst_x) * (COORD_W+STEP_W)'(step_r);
    s0.ok      = ({1'b0, in_ch.dst_x} < dst_w_r) && ({1'b0, in_ch.dst_y} < dst_h_r);
    s0.dst_off = s0.ok ? dy[OFS_W-1:0] : '0;
    s0.col     = xs[FRAC_W+DIM_W-1:FRAC_W];
    // the row quotient stays below src_height, so the upper bits seed the remainder
    s0.rem     = DIM_W'(ny[COORD_W+DIM_W-1:DIM_W]);
    s0.num     = ny[DIM_W-1:0];
    s0.quo     = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_xfer;
      end
      for (int k = 1; k <= DIV_STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_r[0] <= s0;
    end
    for (int k = 1; k <= DIV_STAGES; k++) begin
      if (en[k]) begin
        p_r[k] <= div_bits(p_r[k-1], dst_h_r);
      end
    end
  end

  assign src_sum = (2*DIM_W)'(p_r[DIV_STAGES].quo) * (2*DIM_W)'(src_w_r)
                 + (2*DIM_W)'(p_r[DIV_STAGES].col);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= v_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_src_r <= p_r[DIV_STAGES].ok ? src_sum[OFS_W-1:0] : '0;
      out_dst_r <= p_r[DIV_STAGES].dst_off;
      out_rng_r <= p_r[DIV_STAGES].ok;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.src_byte_ofs = out_src_r;
  assign out_ch.dst_offset   = out_dst_r;
  assign out_ch.in_range     = out_rng_r;

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the nearest-neighbor scaler address unit.
// Drives coordinates and register writes, predicts both byte offsets and the range flag.
// Depends on nnsa_pkg, the channel interfaces in nnsa_if.sv and the top-level RTL.
module tb_top;
  import nnsa_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int PHASES       = 20;
  localparam int PHASE_ITEMS  = 60;

  typedef struct packed {
    logic [OFS_W-1:0] src_byte_ofs;
    logic [OFS_W-1:0] dst_offset;
    logic             in_range;
  } scale_res_t;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_PIXEL,
    ROW_TYPED
  } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    cfg_reg_t           idx;
    logic [DIM_W-1:0]   wdata;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [OFS_W-1:0]   e_src;
    logic [OFS_W-1:0]   e_dst;
    logic               e_in;
  } dir_row_t;

  localparam int DIR_N = 32;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    // defaults after reset: 320 x 200 to 320 x 200
    '{ROW_TYPED, REG_SRC_W, 12'd0,    11'd0,    11'd0,    22'd0,       22'd0,       1'b1},
    '{ROW_TYPED, REG_SRC_W, 12'd0,    11'd319,  11'd199,  22'd63999,   22'd63999,   1'b1},
    '{ROW_TYPED, REG_SRC_W, 12'd0,    11'd320,  11'd0,    22'd0,       22'd0,       1'b0},
    '{ROW_TYPED, REG_SRC_W, 12'd0,    11'd0,    11'd200,  22'd0,       22'd0,       1'b0},
    '{ROW_TYPED, REG_SRC_W, 12'd0,    11'd2047, 11'd2047, 22'd0,       22'd0,       1'b0},
    '{ROW_PIXEL, REG_SRC_W, 12'd0,    11'd100,  11'd50,   22'd0,       22'd0,       1'b0},
    // largest sizes everywhere
    '{ROW_WRITE, REG_SRC_W, 12'd2048, 11'd0,    11'd0,    22'd0,       22'd0,       1'b0},
    '{ROW_WRITE, REG_SRC_H, 12'd2048, 11'd0,    11'd0,    22'd0,       22'd0,       1'b0},
    '{ROW_WRITE, REG_DST_W, 12'd2048, 11'd0,    11'd0,    22'd0,       22'd0,       1'b0},
    '{ROW_WRITE, REG_DST_H, 12'd2048, 11'd0,    11'd0,    22'd0,       22'd0,       1'b0},
    '{ROW_TYPED, REG_SRC_W, 12'd0,    11'd2047, 11'd2047, 22'd4194303, 22'd4194303, 1'b1},
    '{ROW_TYPED, REG_SRC_W, 12'd0,    11'd0,    11'd0,    22'd0,       22'd0,       1'b1},
    // oversized write saturates to the maximum dimension
    '{ROW_WRITE, REG_DST_W, 12'd4095, 11'd0,    11'd0,    22'd0,       22'd0,       1'b0},
    '{ROW_TYPED, REG_SRC_W, 12'd0,    11'd2047, 11'd0,    22'd2047,    22'd2047,    1'b1},
    // fractional column step
    '{ROW_WRITE, REG_SRC_W, 12'd640,  11'd0,    11'd0,    22'd0,       22'd0,       1'b0},
    '{ROW_WRITE, REG_DST_W, 12'd200,  11'd0,    11'd0,    22'd0,       22'd0,       1'b0},
    '{ROW_PIXEL, REG_SRC_W, 12'd0,    11'd199,  11'd1000, 22'd0,       22'd0,       1'b0},
    '{ROW_PIXEL, REG_SRC_W, 12'd0,    11'd123,  11'd2047, 22'd0,       22'd0,       1'b0},
    // zero destination height puts everything outside
    '{ROW_WRITE, REG_DST_H, 12'd0,    11'd0,    11'd0,    22'd0,       22'd0,       1'b0},
    '{ROW_TYPED, REG_SRC_W, 12'd0,    11'd0,    11'd0,    22'd0,       22'd0,       1'b0},
    // zero source sizes give a zero source offset
    '{ROW_WRITE, REG_DST_H, 12'd2048, 11'd0,    11'd0,    22'd0,       22'd0,       1'b0},
    '{ROW_WRITE, REG_SRC_W, 12'd0,    11'd0,    11'd0,    22'd0,       22'd0,       1'b0},
    '{ROW_TYPED, REG_SRC_W, 12'd0,    11'd5,    11'd7,    22'd0,       22'd1405,    1'b1},
    '{ROW_WRITE, REG_SRC_H, 12'd0,    11'd0,    11'd0,    22'd0,       22'd0,       1'b0},
    '{ROW_TYPED, REG_SRC_W, 12'd0,    11'd1,    11'd1,    22'd0,       22'd201,     1'b1},
    // smallest nonzero sizes
    '{ROW_WRITE, REG_SRC_W, 12'd1,    11'd0,    11'd0,    22'd0,       22'd0,       1'b0},
    '{ROW_WRITE, REG_SRC_H, 12'd1,    11'd0,    11'd0,    22'd0,       22'd0,       1'b0},
    '{ROW_WRITE, REG_DST_W, 12'd1,    11'd0,    11'd0,    22'd0,       22'd0,       1'b0},
    '{ROW_WRITE, REG_DST_H, 12'd1,    11'd0,    11'd0,    22'd0,       22'd0,       1'b0},
    '{ROW_TYPED, REG_SRC_W, 12'd0,    11'd0,    11'd0,    22'd0,       22'd0,       1'b1},
    '{ROW_TYPED, REG_SRC_W, 12'd0,    11'd1,    11'd0,    22'd0,       22'd0,       1'b0},
    '{ROW_TYPED, REG_SRC_W, 12'd0,    11'd0,    11'd1,    22'd0,       22'd0,       1'b0}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0] cfg_wdata;

  nnsa_in_if  in_bus ();
  nnsa_out_if out_bus ();

  nearest_neighbor_scale_address dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // shadow copy of the dimension registers
  logic [DIM_W-1:0] sh_src_w = DIM_W'(SRC_W_RST);
  logic [DIM_W-1:0] sh_src_h = DIM_W'(SRC_H_RST);
  logic [DIM_W-1:0] sh_dst_w = DIM_W'(DST_W_RST);
  logic [DIM_W-1:0] sh_dst_h = DIM_W'(DST_H_RST);

  scale_res_t pending_offsets [$];
  scale_res_t head_offsets;
  int mismatches = 0;
  int cycle_count = 0;
  int stall_req = 0;
  bit no_idle = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    return (v > MAX_DIM) ? DIM_W'(MAX_DIM) : v;
  endfunction

  function automatic scale_res_t predict_offsets(input logic [COORD_W-1:0] x,
                                                 input logic [COORD_W-1:0] y);
    scale_res_t r;
    longint unsigned row;
    longint unsigned step;
    longint unsigned col;
    r = '0;
    if (x < sh_dst_w && y < sh_dst_h) begin
      row  = (longint'(y) * longint'(sh_src_h)) / longint'(sh_dst_h);
      step = (longint'(sh_src_w) << FRAC_W) / longint'(sh_dst_w);
      col  = (longint'(x) * step) >> FRAC_W;
      r.src_byte_ofs = OFS_W'(row * longint'(sh_src_w) + col);
      r.dst_offset   = OFS_W'(longint'(y) * longint'(sh_dst_w) + longint'(x));
      r.in_range     = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0:       return '0;
      1, 2:    return DIM_W'(MAX_DIM);
      3, 4:    return DIM_W'($urandom_range(MAX_DIM + 1, 4095));
      5, 6, 7: return DIM_W'($urandom_range(1, MAX_DIM));
      default: return DIM_W'($urandom_range(1, 64));
    endcase
  endfunction

  // mostly inside the destination, some on its edge, some anywhere
  function automatic logic [COORD_W-1:0] pick_coord(input logic [DIM_W-1:0] d);
    int r;
    r = $urandom_range(0, 9);
    if (r <= 6 && d != 0) return COORD_W'($urandom_range(0, int'(d) - 1));
    if (r == 7 && d != 0) return COORD_W'(int'(d) - 1 + $urandom_range(0, 1));
    return COORD_W'($urandom_range(0, 2047));
  endfunction

  task automatic flag_mismatch(input string what, input logic [OFS_W-1:0] got,
                               input logic [OFS_W-1:0] want);
    $display("MISMATCH %s: got %0d want %0d (cycle %0d)", what, got, want, cycle_count);
    mismatches++;
  endtask

  task automatic send_coord(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input scale_res_t want);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.dst_x <= x;
    in_bus.dst_y <= y;
    do @(posedge clk); while (!in_bus.ready);
    pending_offsets.push_back(want);
  endtask

  // drop valid and hold until every transfer in flight has come out
  task automatic drain_pipe();
    in_bus.valid <= 1'b0;
    while (pending_offsets.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_dim(input cfg_reg_t idx, input logic [DIM_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SRC_W: sh_src_w = sat_dim(v);
      REG_SRC_H: sh_src_h = sat_dim(v);
      REG_DST_W: sh_dst_w = sat_dim(v);
      REG_DST_H: sh_dst_h = sat_dim(v);
      default: ;
    endcase
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_offsets.size() == 0) begin
        flag_mismatch("unexpected result src_byte_ofs", out_bus.src_byte_ofs, '0);
      end else begin
        head_offsets = pending_offsets.pop_front();
        if (out_bus.src_byte_ofs !== head_offsets.src_byte_ofs)
          flag_mismatch("src_byte_ofs", out_bus.src_byte_ofs, head_offsets.src_byte_ofs);
        if (out_bus.dst_offset !== head_offsets.dst_offset)
          flag_mismatch("dst_offset", out_bus.dst_offset, head_offsets.dst_offset);
        if (out_bus.in_range !== head_offsets.in_range)
          flag_mismatch("in_range", OFS_W'(out_bus.in_range), OFS_W'(head_offsets.in_range));
      end
    end
  end

  // result side: random hold-off per transfer, plus one long stall on request
  initial begin
    int gap;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (stall_req > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall_req) @(posedge clk);
        stall_req = 0;
      end
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
    end
  end

  initial begin
    dir_row_t row;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_SRC_W;
    cfg_wdata    = '0;
    in_bus.valid = 1'b0;
    in_bus.dst_x = '0;
    in_bus.dst_y = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      row = DIR_TAB[i];
      case (row.kind)
        ROW_WRITE: begin
          drain_pipe();
          write_dim(row.idx, row.wdata);
        end
        ROW_PIXEL: send_coord(row.x, row.y, predict_offsets(row.x, row.y));
        default:   send_coord(row.x, row.y, '{row.e_src, row.e_dst, row.e_in});
      endcase
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_pipe();
      no_idle = (p % 4 == 1) || (p == 6);
      write_dim(REG_SRC_W, pick_dim());
      write_dim(REG_SRC_H, pick_dim());
      write_dim(REG_DST_W, pick_dim());
      write_dim(REG_DST_H, pick_dim());
      // hold the result side off while coordinates keep coming, so the pipe backs up
      if (p == 6) stall_req = 400;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        x = pick_coord(sh_dst_w);
        y = pick_coord(sh_dst_h);
        send_coord(x, y, predict_offsets(x, y));
      end
    end

    drain_pipe();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
src/nnsa_pkg.sv
src/nnsa_if.sv
src/nearest_neighbor_scale_address.sv
verif/tb_top.sv
